>>> rtl/stb_pkg.sv
package stb_pkg;

	localparam logic [1:0] OP_ADD    = 2'd0;
	localparam logic [1:0] OP_RETURN = 2'd1;
	localparam logic [1:0] OP_SEG    = 2'd2;
	localparam logic [1:0] OP_ACK    = 2'd3;

	localparam logic [2:0] STAT_OK      = 3'd0;
	localparam logic [2:0] STAT_NO_ROOM = 3'd1;
	localparam logic [2:0] STAT_EMPTY   = 3'd2;
	localparam logic [2:0] STAT_NO_FIT  = 3'd3;
	localparam logic [2:0] STAT_FULL    = 3'd4;

	localparam int          RESULT_CAP = 32;
	localparam int          RBUF_IW    = 5;
	localparam logic [31:0] RESET_MAX_PENDING = 32'd131072;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_SEG_WALK,
		ST_SEG_COMMIT,
		ST_ACK_WALK,
		ST_EMIT_RD,
		ST_EMIT_LD,
		ST_FIN
	} stb_state_t;

	typedef struct packed {
		logic [15:0] tag;
		logic [15:0] length;
	} pend_entry_t;

	typedef struct packed {
		logic [31:0] number;
		logic [15:0] length;
		logic        acked;
	} sent_entry_t;

	typedef struct packed {
		logic [15:0] tag;
		logic [15:0] length;
		logic [15:0] run;
	} rbuf_entry_t;

	function automatic logic serial_before(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] d;
		d = a - b;
		return d[31];
	endfunction

endpackage

>>> rtl/stb_cmd_if.sv
interface stb_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  operation;
	logic [15:0] item_length;
	logic [15:0] item_tag;
	logic [15:0] byte_budget;
	logic [31:0] packet_number;
	logic [31:0] ack_upper;
	logic [31:0] ack_lower;

	modport source (output valid, operation, item_length, item_tag, byte_budget,
		packet_number, ack_upper, ack_lower, input ready);
	modport sink (input valid, operation, item_length, item_tag, byte_budget,
		packet_number, ack_upper, ack_lower, output ready);
endinterface

>>> rtl/stb_res_if.sv
interface stb_res_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [15:0] taken_tag;
	logic [15:0] taken_length;
	logic [15:0] segment_length;
	logic        last_of_run;
	logic [31:0] pending_bytes;
	logic [31:0] inflight_bytes;
	logic [6:0]  newly_acked;

	modport source (output valid, status, taken_tag, taken_length, segment_length,
		last_of_run, pending_bytes, inflight_bytes, newly_acked, input ready);
	modport sink (input valid, status, taken_tag, taken_length, segment_length,
		last_of_run, pending_bytes, inflight_bytes, newly_acked, output ready);
endinterface

>>> rtl/stream_tx_segment_buffer_unit.sv
// Channel   Dir  Transfer when        Carries
// cmd       in   valid & ready        operation, item, budget, packet/ack numbers
// res       out  valid & ready        status, taken item, totals, ack count
// cfg       in   cfg_we               max_pending_bytes
//
// Add and return pass through IDLE, DECIDE and FIN, as does a segment refused for a full sent list.
// Segment walks the pending list and commits, then emits each taken item through EMIT_RD
// and EMIT_LD, or gives the nothing-fits result through FIN.
// Ack walks the sent list, one sent-memory read per entry, then gives its result through FIN.
// Reset clears counts and totals; the memories need no clearing pass.
// A stalled result holds its register; FIN and EMIT_LD wait for it, no command enters meanwhile.
module stream_tx_segment_buffer_unit
	import stb_pkg::*;
#(
	parameter int PENDING_DEPTH = 32,
	parameter int SENT_DEPTH    = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	stb_cmd_if.sink     cmd,
	stb_res_if.source   res
);

	localparam int PIW = $clog2(PENDING_DEPTH);
	localparam int PCW = $clog2(PENDING_DEPTH + 1);
	localparam int SIW = $clog2(SENT_DEPTH);
	localparam int SCW = $clog2(SENT_DEPTH + 1);

	function automatic logic [PIW-1:0] pwrap(input logic [PIW-1:0] b, input logic [PCW-1:0] o);
		logic [PCW:0] s;
		s = (PCW+1)'(b) + (PCW+1)'(o);
		if (s >= (PCW+1)'(PENDING_DEPTH))
			s = s - (PCW+1)'(PENDING_DEPTH);
		return s[PIW-1:0];
	endfunction

	stb_state_t state_q, state_d;

	pend_entry_t pmem [PENDING_DEPTH];
	sent_entry_t smem [SENT_DEPTH];
	rbuf_entry_t rbuf [RESULT_CAP];

	pend_entry_t p_rdata, p_wdata;
	sent_entry_t s_rdata, s_wdata;
	rbuf_entry_t rb_rdata, rb_wdata;
	logic [PIW-1:0] p_raddr, p_waddr;
	logic [SIW-1:0] s_raddr, s_waddr, saddr_s1;
	logic [RBUF_IW-1:0] rb_waddr;
	logic p_re, p_we, s_re, s_we, rb_we, rb_re;

	logic [31:0] maxp_q, ptot_q, stot_q, room;
	logic [PIW-1:0] head_q, head_dec;
	logic [PCW-1:0] pcnt_q, pidx_q, w_q;
	logic [SCW-1:0] scnt_q, sidx_q;
	logic [5:0]  n_q, k_q;
	logic [15:0] seg_q;
	logic [2:0]  status_q, item_st;
	logic [6:0]  newly_q;
	logic        pv_s1, sv_s1, ov_q;

	logic [1:0]  op_q;
	logic [15:0] len_q, tag_q, budget_q;
	logic [31:0] pn_q, upper_q, lower_q;

	logic p_issue, s_issue, fits, hit, slot_free, res_load, emit_last;
	logic [16:0] cand;

	assign room = (maxp_q >= ptot_q) ? maxp_q - ptot_q : 32'd0;
	assign head_dec = (head_q == '0) ? PIW'(PENDING_DEPTH - 1) : head_q - PIW'(1);

	always_comb begin
		if ({16'd0, len_q} > room)
			item_st = STAT_NO_ROOM;
		else if (len_q == 16'd0)
			item_st = STAT_EMPTY;
		else if (pcnt_q == PCW'(PENDING_DEPTH))
			item_st = STAT_NO_ROOM;
		else
			item_st = STAT_OK;
	end

	assign p_issue = pidx_q < pcnt_q;
	assign s_issue = sidx_q < scnt_q;
	assign cand = {1'b0, seg_q} + {1'b0, p_rdata.length};
	assign fits = (n_q < 6'(RESULT_CAP)) && (cand <= {1'b0, budget_q});
	assign hit = serial_before(lower_q, s_rdata.number) &&
		!serial_before(upper_q, s_rdata.number) && !s_rdata.acked;
	assign slot_free = !ov_q || res.ready;
	assign emit_last = (k_q + 6'd1) == n_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:       if (cmd.valid) state_d = ST_DECIDE;
			ST_DECIDE: begin
				case (op_q)
					OP_SEG:  state_d = (scnt_q == SCW'(SENT_DEPTH)) ? ST_FIN : ST_SEG_WALK;
					OP_ACK:  state_d = ST_ACK_WALK;
					default: state_d = ST_FIN;
				endcase
			end
			ST_SEG_WALK:   if (!p_issue && !pv_s1) state_d = ST_SEG_COMMIT;
			ST_SEG_COMMIT: state_d = (n_q == 6'd0) ? ST_FIN : ST_EMIT_RD;
			ST_ACK_WALK:   if (!s_issue && !sv_s1) state_d = ST_FIN;
			ST_EMIT_RD:    state_d = ST_EMIT_LD;
			ST_EMIT_LD:    if (slot_free) state_d = emit_last ? ST_IDLE : ST_EMIT_RD;
			ST_FIN:        if (slot_free) state_d = ST_IDLE;
			default:       state_d = ST_IDLE;
		endcase
	end

	// memory controls and handshake
	always_comb begin
		cmd.ready = state_q == ST_IDLE;
		p_re = (state_q == ST_SEG_WALK) && p_issue;
		p_raddr = pwrap(head_q, pidx_q);
		p_we = 1'b0;
		p_waddr = pwrap(head_q, w_q);
		p_wdata = p_rdata;
		rb_we = (state_q == ST_SEG_WALK) && pv_s1 && fits;
		rb_waddr = n_q[RBUF_IW-1:0];
		rb_wdata = '{tag: p_rdata.tag, length: p_rdata.length, run: cand[15:0]};
		rb_re = state_q == ST_EMIT_RD;
		s_re = (state_q == ST_ACK_WALK) && s_issue;
		s_raddr = sidx_q[SIW-1:0];
		s_we = 1'b0;
		s_waddr = saddr_s1;
		s_wdata = '{number: s_rdata.number, length: s_rdata.length, acked: 1'b1};
		res_load = ((state_q == ST_EMIT_LD) || (state_q == ST_FIN)) && slot_free;
		case (state_q)
			ST_DECIDE: begin
				if ((op_q == OP_ADD || op_q == OP_RETURN) && item_st == STAT_OK) begin
					p_we = 1'b1;
					p_waddr = (op_q == OP_ADD) ? pwrap(head_q, pcnt_q) : head_dec;
					p_wdata = '{tag: tag_q, length: len_q};
				end
			end
			ST_SEG_WALK:   p_we = pv_s1 && !fits;
			ST_SEG_COMMIT: begin
				s_we = n_q != 6'd0;
				s_waddr = scnt_q[SIW-1:0];
				s_wdata = '{number: pn_q, length: seg_q, acked: 1'b0};
			end
			ST_ACK_WALK:   s_we = sv_s1 && hit;
			default:       ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (p_we) pmem[p_waddr] <= p_wdata;
		if (p_re) p_rdata <= pmem[p_raddr];
	end

	always_ff @(posedge clk) begin
		if (s_we) smem[s_waddr] <= s_wdata;
		if (s_re) s_rdata <= smem[s_raddr];
	end

	always_ff @(posedge clk) begin
		if (rb_we) rbuf[rb_waddr] <= rb_wdata;
		if (rb_re) rb_rdata <= rbuf[k_q[RBUF_IW-1:0]];
	end

	always_ff @(posedge clk) begin
		saddr_s1 <= s_raddr;
		if (cmd.valid && cmd.ready) begin
			op_q     <= cmd.operation;
			len_q    <= cmd.item_length;
			tag_q    <= cmd.item_tag;
			budget_q <= cmd.byte_budget;
			pn_q     <= cmd.packet_number;
			upper_q  <= cmd.ack_upper;
			lower_q  <= cmd.ack_lower;
		end
		if (res_load) begin
			res.pending_bytes  <= ptot_q;
			res.inflight_bytes <= stot_q;
			if (state_q == ST_EMIT_LD) begin
				res.status         <= STAT_OK;
				res.taken_tag      <= rb_rdata.tag;
				res.taken_length   <= rb_rdata.length;
				res.segment_length <= rb_rdata.run;
				res.last_of_run    <= emit_last;
				res.newly_acked    <= 7'd0;
			end else begin
				res.status         <= status_q;
				res.taken_tag      <= 16'd0;
				res.taken_length   <= 16'd0;
				res.segment_length <= 16'd0;
				res.last_of_run    <= 1'b1;
				res.newly_acked    <= newly_q;
			end
		end
	end

	assign res.valid = ov_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			maxp_q   <= RESET_MAX_PENDING;
			ptot_q   <= '0;
			stot_q   <= '0;
			head_q   <= '0;
			pcnt_q   <= '0;
			pidx_q   <= '0;
			w_q      <= '0;
			scnt_q   <= '0;
			sidx_q   <= '0;
			n_q      <= '0;
			k_q      <= '0;
			seg_q    <= '0;
			status_q <= STAT_OK;
			newly_q  <= '0;
			pv_s1    <= 1'b0;
			sv_s1    <= 1'b0;
			ov_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			pv_s1   <= p_re;
			sv_s1   <= s_re;
			if (cfg_we) maxp_q <= cfg_wdata;
			if (res_load) ov_q <= 1'b1;
			else if (res.ready) ov_q <= 1'b0;
			case (state_q)
				ST_DECIDE: begin
					newly_q <= '0;
					pidx_q  <= '0;
					sidx_q  <= '0;
					w_q     <= '0;
					n_q     <= '0;
					seg_q   <= '0;
					case (op_q)
						OP_SEG: status_q <= (scnt_q == SCW'(SENT_DEPTH)) ? STAT_FULL : STAT_OK;
						OP_ACK: status_q <= STAT_OK;
						default: begin
							status_q <= item_st;
							if (item_st == STAT_OK) begin
								pcnt_q <= pcnt_q + PCW'(1);
								ptot_q <= ptot_q + {16'd0, len_q};
								if (op_q == OP_RETURN) begin
									head_q <= head_dec;
									// drop the newest segment
									if (scnt_q != '0) begin
										scnt_q <= scnt_q - SCW'(1);
										stot_q <= (stot_q >= {16'd0, len_q}) ?
											stot_q - {16'd0, len_q} : 32'd0;
									end
								end
							end
						end
					endcase
				end
				ST_SEG_WALK: begin
					if (p_re) pidx_q <= pidx_q + PCW'(1);
					if (pv_s1) begin
						if (fits) begin
							n_q    <= n_q + 6'd1;
							seg_q  <= cand[15:0];
							ptot_q <= ptot_q - {16'd0, p_rdata.length};
						end else begin
							w_q <= w_q + PCW'(1);
						end
					end
					if (!p_issue && !pv_s1) pcnt_q <= w_q;
				end
				ST_SEG_COMMIT: begin
					k_q <= '0;
					if (n_q == 6'd0) begin
						status_q <= STAT_NO_FIT;
					end else begin
						scnt_q <= scnt_q + SCW'(1);
						stot_q <= stot_q + {16'd0, seg_q};
					end
				end
				ST_ACK_WALK: begin
					if (s_re) sidx_q <= sidx_q + SCW'(1);
					if (sv_s1 && hit) newly_q <= newly_q + 7'd1;
				end
				ST_EMIT_LD: if (res_load) k_q <= k_q + 6'd1;
				default: ;
			endcase
		end
	end

endmodule

>>> rtl/stb_chk.sv
module stb_chk
	import stb_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        res_valid,
	input logic        res_ready,
	input logic [2:0]  status,
	input logic [15:0] taken_tag,
	input logic [15:0] taken_length,
	input logic [15:0] segment_length,
	input logic        last_of_run,
	input logic [6:0]  newly_acked
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(status) && $stable(taken_tag) &&
		$stable(segment_length) && $stable(last_of_run))
		else $error("result changed while stalled");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> status <= STAT_FULL)
		else $error("status code out of range");

	a_refuse_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status != STAT_OK |-> last_of_run && taken_length == 16'd0 &&
		segment_length == 16'd0 && newly_acked == 7'd0)
		else $error("refusal result malformed");

	a_run: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && taken_length != 16'd0 |-> segment_length >= taken_length &&
		newly_acked == 7'd0)
		else $error("segment running total below item length");

endmodule

bind stream_tx_segment_buffer_unit stb_chk u_stb_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.res_valid      (res.valid),
	.res_ready      (res.ready),
	.status         (res.status),
	.taken_tag      (res.taken_tag),
	.taken_length   (res.taken_length),
	.segment_length (res.segment_length),
	.last_of_run    (res.last_of_run),
	.newly_acked    (res.newly_acked)
);
